// ----- design/bgc_pkg.sv -----
// Shared types, register indexes and gesture codes for the button gesture classifier.
package bgc_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned CFG_W    = 16;
   localparam int unsigned ELAPSED_W = 8;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CFG_W-1:0] DOUBLE_GAP_RESET = 16'd250;
   localparam logic [CFG_W-1:0] LONG_MIN_RESET   = 16'd300;
   localparam logic [CFG_W-1:0] LONG_MAX_RESET   = 16'd5000;

   localparam logic [CSR_IDX_W-1:0] REG_DOUBLE_GAP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_MIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_MAX   = 2'd2;

   typedef enum logic [2:0] {
      GEST_NONE      = 3'd0,
      GEST_SINGLE    = 3'd1,
      GEST_DOUBLE    = 3'd2,
      GEST_LONG      = 3'd3,
      GEST_VERY_LONG = 3'd4
   } gesture_type;

   typedef struct packed {
      logic [CFG_W-1:0] double_gap_ms;
      logic [CFG_W-1:0] long_min_ms;
      logic [CFG_W-1:0] long_max_ms;
   } cfg_type;

   typedef struct packed {
      logic                 level_pressed;
      logic [ELAPSED_W-1:0] elapsed_ms;
   } sample_type;

endpackage

// ----- design/button_gesture_classifier_top.sv -----
// Button gesture classifier: input register, classification core, result register.
//
// Usage:
//   req_ channel: one sample per item (req_level_pressed, req_elapsed_ms), valid/stall.
//   rsp_ channel: exactly one rsp_gesture per sample, in order
//     (0 none, 1 single, 2 double, 3 long, 4 very long press).
//   csr_ channel: csr_index 0 double gap, 1 long min, 2 long max, 3 ignored;
//     csr_ready is always high, write only while no item is in flight.
//   Order: an accepted sample is held in the input register, then classified
//     into the result register, which drives rsp_valid.
//   Throughput: one item per cycle while no result stalls; the 32-bit time
//     add, three subtracts and compares in bgc_core sit between the input and
//     result registers.
//   Stall: a stalled result holds; the input register still takes one more
//     sample, then req_stall rises until the result is taken.
//   Reset: synchronous; clears time, stamps, pending flag and level
//     (released), empties both registers and loads 250 / 300 / 5000 ms.
module button_gesture_classifier_top import bgc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_level_pressed,
   input  logic [ELAPSED_W-1:0]  req_elapsed_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_gesture,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   cfg_type     cfg_ff;
   sample_type  sample_ff;
   logic        s1_valid_ff, s1_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   gesture_type rsp_gesture_ff;
   gesture_type gesture;
   logic        out_free;
   logic        advance;
   logic        req_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.double_gap_ms <= DOUBLE_GAP_RESET;
         cfg_ff.long_min_ms   <= LONG_MIN_RESET;
         cfg_ff.long_max_ms   <= LONG_MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DOUBLE_GAP: cfg_ff.double_gap_ms <= csr_wdata;
            REG_LONG_MIN:   cfg_ff.long_min_ms   <= csr_wdata;
            REG_LONG_MAX:   cfg_ff.long_max_ms   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      advance      = s1_valid_ff && out_free;
      req_stall    = s1_valid_ff && !out_free;
      req_take     = req_valid && !req_stall;
      s1_valid_in  = req_take || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff.level_pressed <= req_level_pressed;
         sample_ff.elapsed_ms    <= req_elapsed_ms;
      end
      if (advance) begin
         rsp_gesture_ff <= gesture;
      end
   end

   bgc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (sample_ff),
      .cfg     (cfg_ff),
      .gesture (gesture)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_gesture = rsp_gesture_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("input stalled with room available");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_valid_ff && rsp_gesture_ff == $past(gesture)))
      else $error("classified item lost");

   a_gesture_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_gesture_ff <= GEST_VERY_LONG))
      else $error("gesture code out of range");

endmodule

// ----- design/bgc_core.sv -----
// Gesture state (time, press/release stamps, pending flag) and per-item classification.
module bgc_core import bgc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  sample_type  sample,
   input  cfg_type     cfg,
   output gesture_type gesture
);

   logic [TIME_W-1:0] time_ff, time_in;
   logic [TIME_W-1:0] press_ff, press_in;
   logic [TIME_W-1:0] release_ff, release_in;
   logic              pending_ff, pending_in;
   logic              held_ff;

   logic [TIME_W-1:0] now;
   logic [TIME_W-1:0] held_time;
   logic [TIME_W-1:0] since_release;
   logic [TIME_W-1:0] since_press;
   logic              level_edge;
   logic              pend_edge;
   gesture_type       gest_edge;

   always_comb begin
      now        = time_ff + TIME_W'(sample.elapsed_ms);
      level_edge = sample.level_pressed != held_ff;
      press_in   = (level_edge && sample.level_pressed) ? now : press_ff;
      release_in = (level_edge && !sample.level_pressed) ? now : release_ff;

      // release edge toggles pending; a second release is a double press
      pend_edge = pending_ff;
      gest_edge = GEST_NONE;
      if (level_edge && !sample.level_pressed) begin
         pend_edge = !pending_ff;
         if (pending_ff) begin
            gest_edge = GEST_DOUBLE;
         end
      end

      held_time     = release_in - press_in;
      since_release = now - release_in;
      since_press   = now - press_in;

      pending_in = pend_edge;
      gesture    = gest_edge;
      priority if (!sample.level_pressed && pend_edge &&
                   since_release > TIME_W'(cfg.double_gap_ms)) begin
         pending_in = 1'b0;
         gesture    = GEST_SINGLE;
      end else if (!sample.level_pressed && pend_edge &&
                   held_time >= TIME_W'(cfg.long_min_ms) &&
                   held_time <= TIME_W'(cfg.long_max_ms)) begin
         pending_in = 1'b0;
         gesture    = GEST_LONG;
      end else if (sample.level_pressed && since_press > TIME_W'(cfg.long_max_ms)) begin
         pending_in = 1'b0;
         gesture    = GEST_VERY_LONG;
      end
      time_in = now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff    <= '0;
         press_ff   <= '0;
         release_ff <= '0;
         pending_ff <= 1'b0;
         held_ff    <= 1'b0;
      end else if (advance) begin
         time_ff    <= time_in;
         press_ff   <= press_in;
         release_ff <= release_in;
         pending_ff <= pending_in;
         held_ff    <= sample.level_pressed;
      end
   end

   a_double_on_release: assert property (@(posedge clock) disable iff (reset)
      (advance && gesture == GEST_DOUBLE) |-> (held_ff && !sample.level_pressed && pending_ff))
      else $error("double press without a release of a pending press");

   a_level_tracked: assert property (@(posedge clock) disable iff (reset)
      advance |=> (held_ff == $past(sample.level_pressed)))
      else $error("held level not updated");

   a_long_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (advance && (gesture == GEST_SINGLE || gesture == GEST_LONG)) |=> !pending_ff)
      else $error("pending press survives a resolved gesture");

endmodule
